### hw/rtl/lark4_pkg.sv
// Shared widths, register map, constants and arithmetic helpers of the actuator RK4 step.
`timescale 1ns / 1ps

package lark4_pkg;

   // Field widths.
   localparam int WORD_W        = 32;
   localparam int CMD_W         = 16;
   localparam int CMD_FRAC_BITS = 14;
   localparam int PROD_W        = 64;
   localparam int NUM_STATES    = 4;
   localparam int NUM_REGS      = 8;
   localparam int CSR_INDEX_W   = 3;

   // The weighted sum d1 + 2 d2 + 2 d3 + d4 stays within six times the word range.
   localparam int ACC_W = WORD_W + 3;

   // Each increment takes a product, a sum and, but for the last, a half-step stage.
   localparam int STG_PER_INC = 3;
   localparam int STG_SUM     = STG_PER_INC * (NUM_STATES - 1) + 2;
   localparam int STG_DIV_HI  = STG_SUM + 1;
   localparam int STG_DIV_LO  = STG_SUM + 2;
   localparam int STG_OUT     = STG_SUM + 3;
   localparam int NUM_STAGES  = STG_OUT + 1;

   // Division by six: halve, then divide by three in two 16-bit digits.
   localparam int DIV_IN_W     = 33;
   localparam int DIV_LO_W     = 16;
   localparam int DIV_HI_W     = DIV_IN_W - DIV_LO_W;
   localparam int DIV_Q_W      = 16;
   localparam int DIV3_IN_W    = 18;
   localparam int DIV3_MUL_W   = 19;
   localparam int DIV3_PROD_W  = DIV3_IN_W + DIV3_MUL_W;
   localparam int DIV3_SHIFT   = DIV3_IN_W + 2;
   localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 19'd349526;

   // Saturation limits, held at product width.
   localparam logic signed [PROD_W-1:0] WORD_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [PROD_W-1:0] WORD_MIN = -64'sh0000_0000_8000_0000;

   typedef logic signed [WORD_W-1:0] word_type;

   // Coefficient register map.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SPRING_FROM_LOAD_SPEED,
      REG_SPRING_FROM_MOTOR_SPEED,
      REG_POSITION_FROM_SPEED,
      REG_LOAD_FROM_SPRING,
      REG_LOAD_FRICTION,
      REG_MOTOR_FROM_SPRING,
      REG_MOTOR_FRICTION,
      REG_DRIVE_GAIN
   } reg_index_type;

   // State vector order.
   typedef enum logic [1:0] {
      ST_SPRING,
      ST_POSITION,
      ST_LOAD_SPEED,
      ST_MOTOR_SPEED
   } state_index_type;

   localparam word_type COEF_RESET [NUM_REGS] = '{
      32'sd15784005, -32'sd164246, 32'sd26844, -32'sd315806419,
      -32'sd87794176, 32'sd15263777, -32'sd82877, 32'sd84784534
   };

   // What travels alongside the arithmetic through every stage before the output.
   typedef struct packed {
      logic [NUM_STATES-1:0][WORD_W-1:0] x;
      logic [CMD_W-1:0]                  cmd;
      logic [NUM_STATES-1:0][ACC_W-1:0]  acc;
      logic                              ovf;
   } carry_type;

   // Add half an LSB, then shift right with floor.
   function automatic logic signed [PROD_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] v,
      input int unsigned              s
   );
      logic signed [PROD_W-1:0] half;
      half = '0;
      half[s - 1] = 1'b1;
      return (v + half) >>> s;
   endfunction

   function automatic logic word_overflow(input logic signed [PROD_W-1:0] v);
      return (v > WORD_MAX) || (v < WORD_MIN);
   endfunction

   function automatic word_type sat_word(input logic signed [PROD_W-1:0] v);
      word_type r;
      if (v > WORD_MAX) begin
         r = WORD_MAX[WORD_W-1:0];
      end else if (v < WORD_MIN) begin
         r = WORD_MIN[WORD_W-1:0];
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/linear_actuator_rk4_step.sv
// Pipelined fourth-order Runge-Kutta step of the four-state linear actuator model.
`timescale 1ns / 1ps

// Unless stalled, one request enters every cycle, so the block sustains one state update
// per clock. The pipeline holds the four chained increment evaluations, each a multiply
// stage, a round-and-sum stage and, bar the last, a half-step stage, then the weighted sum,
// a two-digit division by six and an output stage. A stalled result holds the pipeline only
// as far back as it is full: bubbles still close up and new requests are taken while a free
// slot remains. The eight coefficients reset to the model's defaults and may be rewritten
// at any time the pipeline is empty; there is no memory and no clearing pass.
module linear_actuator_rk4_step #(
   parameter int STATE_FRAC_BITS = 16,
   parameter int COEF_FRAC_BITS  = 28
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [31:0] req_spring_torque_in,
   input  logic signed [31:0] req_position_in,
   input  logic signed [31:0] req_load_speed_in,
   input  logic signed [31:0] req_motor_speed_in,
   input  logic signed [15:0] req_command_in,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_spring_torque_out,
   output logic signed [31:0] rsp_position_out,
   output logic signed [31:0] rsp_load_speed_out,
   output logic signed [31:0] rsp_motor_speed_out,
   output logic        rsp_overflow,

   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int WORD_W      = lark4_pkg::WORD_W;
   localparam int PROD_W      = lark4_pkg::PROD_W;
   localparam int ACC_W       = lark4_pkg::ACC_W;
   localparam int SUM_W       = WORD_W + 2;
   localparam int NS          = lark4_pkg::NUM_STATES;
   localparam int N           = lark4_pkg::NUM_STAGES;
   localparam int SPI         = lark4_pkg::STG_PER_INC;
   localparam int DIV_HI_W    = lark4_pkg::DIV_HI_W;
   localparam int DIV_LO_W    = lark4_pkg::DIV_LO_W;
   localparam int DIV_IN_W    = lark4_pkg::DIV_IN_W;
   localparam int DIV_Q_W     = lark4_pkg::DIV_Q_W;
   localparam int DIV3_IN_W   = lark4_pkg::DIV3_IN_W;
   localparam int DIV3_PROD_W = lark4_pkg::DIV3_PROD_W;
   localparam int DRIVE_SHIFT = COEF_FRAC_BITS + lark4_pkg::CMD_FRAC_BITS - STATE_FRAC_BITS;

   // Coefficient registers.
   lark4_pkg::word_type coef_ff [lark4_pkg::NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lark4_pkg::NUM_REGS; i++) begin
            coef_ff[i] <= lark4_pkg::COEF_RESET[i];
         end
      end else if (csr_write) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // Valid bits and flow control. A stage may load when some stage at or after it is
   // empty, or the result is being taken.
   logic [N-1:0] vld_ff;
   logic [N-1:0] rdy;

   for (genvar g = 0; g < N; g++) begin : g_rdy
      assign rdy[g] = !(&vld_ff[N-1:g]) || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int s = 1; s < N; s++) begin
            if (rdy[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[N-1];

   // Side information that travels with each request.
   lark4_pkg::carry_type carry_in [N-1];
   lark4_pkg::carry_type carry_ff [N-1];

   logic [NS-1:0]                  inc_ovf;
   logic [NS-2:0]                  half_ovf;
   logic [NS-1:0][ACC_W-1:0]       acc_next [NS-1];
   lark4_pkg::word_type            d_ff [NS][NS];
   lark4_pkg::word_type            t_ff [NS-1][NS];

   always_comb begin
      carry_in[0].x   = {req_motor_speed_in, req_load_speed_in, req_position_in,
                         req_spring_torque_in};
      carry_in[0].cmd = req_command_in;
      carry_in[0].acc = '0;
      carry_in[0].ovf = 1'b0;
      for (int s = 1; s < N - 1; s++) begin
         carry_in[s] = carry_ff[s-1];
      end
      for (int k = 0; k < NS; k++) begin
         carry_in[SPI*k+1].ovf = carry_ff[SPI*k].ovf | inc_ovf[k];
      end
      for (int k = 0; k < NS - 1; k++) begin
         carry_in[SPI*k+2].ovf = carry_ff[SPI*k+1].ovf | half_ovf[k];
         carry_in[SPI*k+2].acc = acc_next[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < N - 1; s++) begin
         if (rdy[s]) begin
            carry_ff[s] <= carry_in[s];
         end
      end
   end

   // The four increment evaluations, each followed (except the last) by its half step.
   for (genvar k = 0; k < NS; k++) begin : g_inc
      lark4_pkg::word_type       src [NS];
      logic signed [15:0]        cmd;
      logic signed [PROD_W-1:0]  prod_in [lark4_pkg::NUM_REGS];
      logic signed [PROD_W-1:0]  prod_ff [lark4_pkg::NUM_REGS];
      logic signed [PROD_W-1:0]  term [lark4_pkg::NUM_REGS];
      logic signed [PROD_W-1:0]  sum [NS];
      logic [NS-1:0]             d_sat;

      // State that feeds this increment: the request itself or the last half step.
      if (k == 0) begin : g_src_req
         assign src[lark4_pkg::ST_SPRING]      = req_spring_torque_in;
         assign src[lark4_pkg::ST_POSITION]    = req_position_in;
         assign src[lark4_pkg::ST_LOAD_SPEED]  = req_load_speed_in;
         assign src[lark4_pkg::ST_MOTOR_SPEED] = req_motor_speed_in;
         assign cmd = req_command_in;
      end else begin : g_src_stage
         for (genvar i = 0; i < NS; i++) begin : g_src
            assign src[i] = t_ff[k-1][i];
         end
         assign cmd = $signed(carry_ff[SPI*k-1].cmd);
      end

      // Coefficient products.
      always_comb begin
         prod_in[lark4_pkg::REG_SPRING_FROM_LOAD_SPEED] =
            coef_ff[lark4_pkg::REG_SPRING_FROM_LOAD_SPEED] * src[lark4_pkg::ST_LOAD_SPEED];
         prod_in[lark4_pkg::REG_SPRING_FROM_MOTOR_SPEED] =
            coef_ff[lark4_pkg::REG_SPRING_FROM_MOTOR_SPEED] * src[lark4_pkg::ST_MOTOR_SPEED];
         prod_in[lark4_pkg::REG_POSITION_FROM_SPEED] =
            coef_ff[lark4_pkg::REG_POSITION_FROM_SPEED] * src[lark4_pkg::ST_LOAD_SPEED];
         prod_in[lark4_pkg::REG_LOAD_FROM_SPRING] =
            coef_ff[lark4_pkg::REG_LOAD_FROM_SPRING] * src[lark4_pkg::ST_SPRING];
         prod_in[lark4_pkg::REG_LOAD_FRICTION] =
            coef_ff[lark4_pkg::REG_LOAD_FRICTION] * src[lark4_pkg::ST_LOAD_SPEED];
         prod_in[lark4_pkg::REG_MOTOR_FROM_SPRING] =
            coef_ff[lark4_pkg::REG_MOTOR_FROM_SPRING] * src[lark4_pkg::ST_SPRING];
         prod_in[lark4_pkg::REG_MOTOR_FRICTION] =
            coef_ff[lark4_pkg::REG_MOTOR_FRICTION] * src[lark4_pkg::ST_MOTOR_SPEED];
         prod_in[lark4_pkg::REG_DRIVE_GAIN] =
            coef_ff[lark4_pkg::REG_DRIVE_GAIN] * cmd;
      end

      always_ff @(posedge clock) begin
         if (rdy[SPI*k]) begin
            prod_ff <= prod_in;
         end
      end

      // Round each product to the state format, sum the rows and saturate.
      always_comb begin
         for (int r = 0; r < lark4_pkg::NUM_REGS - 1; r++) begin
            term[r] = lark4_pkg::round_shift(prod_ff[r], COEF_FRAC_BITS);
         end
         term[lark4_pkg::REG_DRIVE_GAIN] =
            lark4_pkg::round_shift(prod_ff[lark4_pkg::REG_DRIVE_GAIN], DRIVE_SHIFT);
         sum[lark4_pkg::ST_SPRING] = term[lark4_pkg::REG_SPRING_FROM_LOAD_SPEED]
                                   + term[lark4_pkg::REG_SPRING_FROM_MOTOR_SPEED];
         sum[lark4_pkg::ST_POSITION] = term[lark4_pkg::REG_POSITION_FROM_SPEED];
         sum[lark4_pkg::ST_LOAD_SPEED] = term[lark4_pkg::REG_LOAD_FROM_SPRING]
                                       + term[lark4_pkg::REG_LOAD_FRICTION];
         sum[lark4_pkg::ST_MOTOR_SPEED] = term[lark4_pkg::REG_MOTOR_FROM_SPRING]
                                        + term[lark4_pkg::REG_MOTOR_FRICTION]
                                        + term[lark4_pkg::REG_DRIVE_GAIN];
         for (int i = 0; i < NS; i++) begin
            d_sat[i] = lark4_pkg::word_overflow(sum[i]);
         end
      end

      assign inc_ovf[k] = |d_sat;

      always_ff @(posedge clock) begin
         if (rdy[SPI*k+1]) begin
            for (int i = 0; i < NS; i++) begin
               d_ff[k][i] <= lark4_pkg::sat_word(sum[i]);
            end
         end
      end

      // Half step for the next evaluation, and the running weighted sum.
      if (k < NS - 1) begin : g_half
         logic signed [WORD_W:0]   step [NS];
         logic signed [WORD_W:0]   x_sum [NS];
         lark4_pkg::word_type      t_in [NS];
         logic [NS-1:0]            t_sat;

         always_comb begin
            for (int i = 0; i < NS; i++) begin
               if (k < NS - 2) begin
                  step[i] = ((WORD_W + 1)'(d_ff[k][i]) + (WORD_W + 1)'(1)) >>> 1;
               end else begin
                  step[i] = (WORD_W + 1)'(d_ff[k][i]);
               end
               x_sum[i] = (WORD_W + 1)'($signed(carry_ff[SPI*k+1].x[i])) + step[i];
               t_in[i]  = lark4_pkg::sat_word(PROD_W'(x_sum[i]));
               t_sat[i] = lark4_pkg::word_overflow(PROD_W'(x_sum[i]));
               if (k == 0) begin
                  acc_next[k][i] = ACC_W'(d_ff[k][i]);
               end else begin
                  acc_next[k][i] = $signed(carry_ff[SPI*k+1].acc[i])
                                 + (ACC_W'(d_ff[k][i]) <<< 1);
               end
            end
         end

         assign half_ovf[k] = |t_sat;

         always_ff @(posedge clock) begin
            if (rdy[SPI*k+2]) begin
               t_ff[k] <= t_in;
            end
         end
      end
   end

   // Final weighted sum, its magnitude plus three, halved.
   logic signed [ACC_W-1:0]  fsum [NS];
   logic [ACC_W-1:0]         fmag [NS];
   logic [ACC_W-1:0]         fmag3 [NS];
   logic [DIV_IN_W-1:0]      f1_v_ff [NS];
   logic [NS-1:0]            f1_neg_ff;

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         fsum[i]  = $signed(carry_ff[lark4_pkg::STG_SUM-1].acc[i]) + ACC_W'(d_ff[NS-1][i]);
         fmag[i]  = fsum[i][ACC_W-1] ? -fsum[i] : fsum[i];
         fmag3[i] = fmag[i] + ACC_W'(3);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[lark4_pkg::STG_SUM]) begin
         for (int i = 0; i < NS; i++) begin
            f1_v_ff[i]   <= fmag3[i][DIV_IN_W:1];
            f1_neg_ff[i] <= fsum[i][ACC_W-1];
         end
      end
   end

   // Divide by three, upper digit: reciprocal multiply.
   logic [DIV3_PROD_W-1:0]   qh_prod [NS];
   logic [DIV_Q_W-1:0]       f2_qh_ff [NS];
   logic [DIV_HI_W-1:0]      f2_hi_ff [NS];
   logic [DIV_LO_W-1:0]      f2_lo_ff [NS];
   logic [NS-1:0]            f2_neg_ff;

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         qh_prod[i] = DIV3_PROD_W'(f1_v_ff[i][DIV_IN_W-1:DIV_LO_W])
                    * DIV3_PROD_W'(lark4_pkg::DIV3_MUL);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[lark4_pkg::STG_DIV_HI]) begin
         for (int i = 0; i < NS; i++) begin
            f2_qh_ff[i]  <= qh_prod[i][lark4_pkg::DIV3_SHIFT +: DIV_Q_W];
            f2_hi_ff[i]  <= f1_v_ff[i][DIV_IN_W-1:DIV_LO_W];
            f2_lo_ff[i]  <= f1_v_ff[i][DIV_LO_W-1:0];
         end
         f2_neg_ff <= f1_neg_ff;
      end
   end

   // Divide by three, lower digit: remainder of the upper digit joins the low half.
   logic [DIV_HI_W-1:0]      hi_rem [NS];
   logic [DIV3_IN_W-1:0]     lo_num [NS];
   logic [DIV3_PROD_W-1:0]   qw_prod [NS];
   logic [DIV_Q_W-1:0]       f3_qh_ff [NS];
   logic [DIV_Q_W-1:0]       f3_qw_ff [NS];
   logic [NS-1:0]            f3_neg_ff;

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         hi_rem[i]  = f2_hi_ff[i] - (DIV_HI_W'({f2_qh_ff[i], 1'b0}) + DIV_HI_W'(f2_qh_ff[i]));
         lo_num[i]  = {hi_rem[i][1:0], f2_lo_ff[i]};
         qw_prod[i] = DIV3_PROD_W'(lo_num[i]) * DIV3_PROD_W'(lark4_pkg::DIV3_MUL);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[lark4_pkg::STG_DIV_LO]) begin
         for (int i = 0; i < NS; i++) begin
            f3_qh_ff[i] <= f2_qh_ff[i];
            f3_qw_ff[i] <= qw_prod[i][lark4_pkg::DIV3_SHIFT +: DIV_Q_W];
         end
         f3_neg_ff <= f2_neg_ff;
      end
   end

   // Apply the signed step to the starting state and saturate into the result register.
   logic signed [SUM_W-1:0]  qs [NS];
   logic signed [SUM_W-1:0]  nx [NS];
   logic [NS-1:0]            nx_sat;
   lark4_pkg::word_type      rsp_state_ff [NS];
   logic                     rsp_ovf_ff;

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         qs[i] = f3_neg_ff[i] ? -SUM_W'({f3_qh_ff[i], f3_qw_ff[i]})
                              : SUM_W'({f3_qh_ff[i], f3_qw_ff[i]});
         nx[i] = SUM_W'($signed(carry_ff[lark4_pkg::STG_OUT-1].x[i])) + qs[i];
         nx_sat[i] = lark4_pkg::word_overflow(PROD_W'(nx[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[lark4_pkg::STG_OUT]) begin
         for (int i = 0; i < NS; i++) begin
            rsp_state_ff[i] <= lark4_pkg::sat_word(PROD_W'(nx[i]));
         end
         rsp_ovf_ff <= carry_ff[lark4_pkg::STG_OUT-1].ovf | (|nx_sat);
      end
   end

   assign rsp_spring_torque_out = rsp_state_ff[lark4_pkg::ST_SPRING];
   assign rsp_position_out      = rsp_state_ff[lark4_pkg::ST_POSITION];
   assign rsp_load_speed_out    = rsp_state_ff[lark4_pkg::ST_LOAD_SPEED];
   assign rsp_motor_speed_out   = rsp_state_ff[lark4_pkg::ST_MOTOR_SPEED];
   assign rsp_overflow          = rsp_ovf_ff;

   // An accepted request always occupies the first stage afterwards.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   // Requests are refused only when every stage is full and the result is held.
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff) && rsp_stall)
      else $error("request refused while the pipeline had room");

   // A result taken with nothing behind it leaves the output empty.
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !vld_ff[N-2] |=> !rsp_valid)
      else $error("result repeated on the output");

   // The upper quotient digit must leave a remainder below three.
   for (genvar i = 0; i < NS; i++) begin : g_chk_div
      a_div_rem: assert property (@(posedge clock) disable iff (reset)
         vld_ff[lark4_pkg::STG_DIV_HI] |-> hi_rem[i] < DIV_HI_W'(3))
         else $error("division remainder out of range");
   end

endmodule

### sim/tb_top.sv
// Self-checking testbench for the pipelined actuator RK4 step.
`timescale 1ns / 1ps

module tb_top;

   localparam int STATE_FRAC      = 16;
   localparam int COEF_FRAC       = 28;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 166;

   localparam int WORD_W        = lark4_pkg::WORD_W;
   localparam int CMD_W         = lark4_pkg::CMD_W;
   localparam int CMD_FRAC_BITS = lark4_pkg::CMD_FRAC_BITS;
   localparam int NUM_REGS      = lark4_pkg::NUM_REGS;
   localparam int CSR_INDEX_W   = lark4_pkg::CSR_INDEX_W;

   localparam longint WORD_HI = 64'sd2147483647;
   localparam longint WORD_LO = -64'sd2147483648;

   typedef lark4_pkg::word_type word_type;
   typedef logic signed [CMD_W-1:0] command_type;

   localparam word_type    W_MAX   = 32'sh7FFF_FFFF;
   localparam word_type    W_MIN   = 32'sh8000_0000;
   localparam command_type CMD_ONE = 16'sd16384;
   localparam command_type CMD_MAX = 16'sh7FFF;
   localparam command_type CMD_MIN = 16'sh8000;

   // Coefficient values after reset, dt already folded in.
   localparam word_type DEFAULT_COEFS [NUM_REGS] = '{
      32'sd15784005, -32'sd164246, 32'sd26844, -32'sd315806419,
      -32'sd87794176, 32'sd15263777, -32'sd82877, 32'sd84784534
   };

   typedef enum int {
      COEFS_DEFAULT,
      COEFS_WIDE,
      COEFS_TOP,
      COEFS_BOTTOM,
      COEFS_NONE,
      COEFS_NEAR
   } coef_set_type;

   typedef struct packed {
      word_type    spring;
      word_type    position;
      word_type    load_speed;
      word_type    motor_speed;
      command_type command;
   } request_type;

   typedef struct packed {
      word_type spring;
      word_type position;
      word_type load_speed;
      word_type motor_speed;
      logic     overflow;
   } next_state_type;

   typedef struct packed {
      request_type    stim;
      logic           typed;
      next_state_type want;
   } directed_row_type;

   // Wide working copy of the plant state used by the predictor.
   typedef struct packed {
      longint spring;
      longint position;
      longint load_speed;
      longint motor_speed;
   } plant_state_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   word_type    req_spring_torque_in;
   word_type    req_position_in;
   word_type    req_load_speed_in;
   word_type    req_motor_speed_in;
   command_type req_command_in;
   logic        rsp_valid;
   logic        rsp_stall;
   word_type    rsp_spring_torque_out;
   word_type    rsp_position_out;
   word_type    rsp_load_speed_out;
   word_type    rsp_motor_speed_out;
   logic        rsp_overflow;
   logic        csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_wdata;

   longint         coef [NUM_REGS];
   next_state_type pending_states [$];
   bit             step_saturated;
   bit             idling_on = 1'b1;
   int             hold_left = 0;
   int             error_count = 0;
   int             results_checked = 0;

   // Directed requests; the expectation is typed in only where it is obvious.
   directed_row_type directed_table [20] = '{
      '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0}, 1'b1,
        '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0}},
      '{'{32'sd0, W_MAX, 32'sd0, 32'sd0, 16'sd0}, 1'b1,
        '{32'sd0, W_MAX, 32'sd0, 32'sd0, 1'b0}},
      '{'{32'sd0, W_MIN, 32'sd0, 32'sd0, 16'sd0}, 1'b1,
        '{32'sd0, W_MIN, 32'sd0, 32'sd0, 1'b0}},
      '{'{W_MAX, W_MAX, W_MAX, W_MAX, CMD_ONE}, 1'b0, '0},
      '{'{W_MIN, W_MIN, W_MIN, W_MIN, -CMD_ONE}, 1'b0, '0},
      '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, CMD_ONE}, 1'b0, '0},
      '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, -CMD_ONE}, 1'b0, '0},
      '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, CMD_MAX}, 1'b0, '0},
      '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, CMD_MIN}, 1'b0, '0},
      '{'{W_MAX, 32'sd0, 32'sd0, 32'sd0, 16'sd0}, 1'b0, '0},
      '{'{W_MIN, 32'sd0, 32'sd0, 32'sd0, 16'sd0}, 1'b0, '0},
      '{'{32'sd0, 32'sd0, W_MAX, 32'sd0, 16'sd0}, 1'b0, '0},
      '{'{32'sd0, 32'sd0, W_MIN, 32'sd0, 16'sd0}, 1'b0, '0},
      '{'{32'sd0, 32'sd0, 32'sd0, W_MAX, 16'sd0}, 1'b0, '0},
      '{'{32'sd0, 32'sd0, 32'sd0, W_MIN, 16'sd0}, 1'b0, '0},
      '{'{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -16'sd1}, 1'b0, '0},
      '{'{32'sd1, 32'sd1, 32'sd1, 32'sd1, 16'sd1}, 1'b0, '0},
      '{'{32'sd65536, 32'sd0, 32'sd32768, -32'sd131072, 16'sd8192}, 1'b0, '0},
      '{'{W_MAX, W_MIN, W_MIN, W_MAX, CMD_MIN}, 1'b0, '0},
      '{'{32'sd32768, -32'sd32768, 32'sd98304, -32'sd98304, -16'sd8192}, 1'b0, '0}
   };

   linear_actuator_rk4_step #(
      .STATE_FRAC_BITS(STATE_FRAC),
      .COEF_FRAC_BITS (COEF_FRAC)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_spring_torque_in (req_spring_torque_in),
      .req_position_in      (req_position_in),
      .req_load_speed_in    (req_load_speed_in),
      .req_motor_speed_in   (req_motor_speed_in),
      .req_command_in       (req_command_in),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_spring_torque_out(rsp_spring_torque_out),
      .rsp_position_out     (rsp_position_out),
      .rsp_load_speed_out   (rsp_load_speed_out),
      .rsp_motor_speed_out  (rsp_motor_speed_out),
      .rsp_overflow         (rsp_overflow),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Round half up: add half an LSB, then shift right arithmetically.
   function automatic longint round_half_up(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   // Clamp to the 32-bit range and note any saturation for this step.
   function automatic longint clamp_word(longint v);
      if (v > WORD_HI) begin
         step_saturated = 1'b1;
         return WORD_HI;
      end
      if (v < WORD_LO) begin
         step_saturated = 1'b1;
         return WORD_LO;
      end
      return v;
   endfunction

   function automatic longint scaled(lark4_pkg::reg_index_type r, longint v);
      return round_half_up(coef[r] * v, COEF_FRAC);
   endfunction

   // One increment of the discretised model: d = Ad x + Bd u.
   function automatic plant_state_type state_rates(plant_state_type x, longint u);
      plant_state_type d;
      longint drive;
      drive = round_half_up(coef[lark4_pkg::REG_DRIVE_GAIN] * u,
                            COEF_FRAC + CMD_FRAC_BITS - STATE_FRAC);
      d.spring = clamp_word(scaled(lark4_pkg::REG_SPRING_FROM_LOAD_SPEED, x.load_speed)
                            + scaled(lark4_pkg::REG_SPRING_FROM_MOTOR_SPEED, x.motor_speed));
      d.position = clamp_word(scaled(lark4_pkg::REG_POSITION_FROM_SPEED, x.load_speed));
      d.load_speed = clamp_word(scaled(lark4_pkg::REG_LOAD_FROM_SPRING, x.spring)
                                + scaled(lark4_pkg::REG_LOAD_FRICTION, x.load_speed));
      d.motor_speed = clamp_word(scaled(lark4_pkg::REG_MOTOR_FROM_SPRING, x.spring)
                                 + scaled(lark4_pkg::REG_MOTOR_FRICTION, x.motor_speed)
                                 + drive);
      return d;
   endfunction

   // Intermediate stage state, x plus the whole or half an increment.
   function automatic plant_state_type stage_state(plant_state_type x, plant_state_type d,
                                                   bit halve);
      plant_state_type t;
      t.spring      = clamp_word(x.spring + (halve ? round_half_up(d.spring, 1) : d.spring));
      t.position    = clamp_word(x.position
                                 + (halve ? round_half_up(d.position, 1) : d.position));
      t.load_speed  = clamp_word(x.load_speed
                                 + (halve ? round_half_up(d.load_speed, 1) : d.load_speed));
      t.motor_speed = clamp_word(x.motor_speed
                                 + (halve ? round_half_up(d.motor_speed, 1) : d.motor_speed));
      return t;
   endfunction

   // Weighted RK4 average, divided by six with rounding away from zero.
   function automatic longint rk4_blend(longint x, longint d1, longint d2, longint d3,
                                        longint d4);
      longint total;
      longint q;
      total = d1 + 2 * d2 + 2 * d3 + d4;
      q = ((total < 0) ? -total : total) + 3;
      q = q / 6;
      return clamp_word(x + ((total < 0) ? -q : q));
   endfunction

   function automatic next_state_type rk4_next_state(request_type r);
      plant_state_type x, d1, d2, d3, d4;
      longint u;
      next_state_type n;
      step_saturated = 1'b0;
      x.spring      = $signed(r.spring);
      x.position    = $signed(r.position);
      x.load_speed  = $signed(r.load_speed);
      x.motor_speed = $signed(r.motor_speed);
      u = $signed(r.command);
      d1 = state_rates(x, u);
      d2 = state_rates(stage_state(x, d1, 1'b1), u);
      d3 = state_rates(stage_state(x, d2, 1'b1), u);
      d4 = state_rates(stage_state(x, d3, 1'b0), u);
      n.spring = word_type'(rk4_blend(x.spring, d1.spring, d2.spring, d3.spring, d4.spring));
      n.position = word_type'(rk4_blend(x.position, d1.position, d2.position, d3.position,
                                        d4.position));
      n.load_speed = word_type'(rk4_blend(x.load_speed, d1.load_speed, d2.load_speed,
                                          d3.load_speed, d4.load_speed));
      n.motor_speed = word_type'(rk4_blend(x.motor_speed, d1.motor_speed, d2.motor_speed,
                                           d3.motor_speed, d4.motor_speed));
      n.overflow = step_saturated;
      return n;
   endfunction

   // State values: full range, small and medium magnitudes, and the edges.
   function automatic word_type pick_word();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
         return word_type'($urandom);
      end else if (sel < 7) begin
         return word_type'(int'($urandom_range(0, 2097151)) - 1048576);
      end else if (sel < 9) begin
         return word_type'(int'($urandom_range(0, 134217727)) - 67108864);
      end
      case ($urandom_range(0, 4))
         0: return W_MAX;
         1: return W_MIN;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   // Commands: mostly within minus one to one, some anywhere in 16 bits.
   function automatic command_type pick_command();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel < 17) begin
         return command_type'(int'($urandom_range(0, 32768)) - 16384);
      end else if (sel < 19) begin
         return command_type'($urandom);
      end
      case ($urandom_range(0, 3))
         0: return CMD_MAX;
         1: return CMD_MIN;
         2: return CMD_ONE;
         default: return -CMD_ONE;
      endcase
   endfunction

   function automatic request_type random_request();
      request_type r;
      r.spring      = pick_word();
      r.position    = pick_word();
      r.load_speed  = pick_word();
      r.motor_speed = pick_word();
      r.command     = pick_command();
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      $display("ERROR: result %0d, %s: got %0d, expected %0d",
               results_checked, what, got, want);
   endtask

   // Offer one request and hold it until accepted, then queue its expected next state.
   task automatic offer(input request_type r, input bit typed, input next_state_type want);
      req_valid            <= 1'b1;
      req_spring_torque_in <= r.spring;
      req_position_in      <= r.position;
      req_load_speed_in    <= r.load_speed;
      req_motor_speed_in   <= r.motor_speed;
      req_command_in       <= r.command;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pending_states.push_back(typed ? want : rk4_next_state(r));
   endtask

   task automatic wait_for_results();
      while (pending_states.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Rewrite all eight coefficients; only called with the pipeline empty.
   task automatic load_coefs(input coef_set_type kind);
      word_type value;
      for (int r = 0; r < NUM_REGS; r++) begin
         case (kind)
            COEFS_WIDE:   value = word_type'($urandom);
            COEFS_TOP:    value = W_MAX;
            COEFS_BOTTOM: value = W_MIN;
            COEFS_NONE:   value = 32'sd0;
            COEFS_NEAR: begin
               value = word_type'(longint'(DEFAULT_COEFS[r]) * int'($urandom_range(1, 48)) / 16);
               if ($urandom_range(0, 3) == 0) value = -value;
            end
            default:      value = DEFAULT_COEFS[r];
         endcase
         csr_write <= 1'b1;
         csr_index <= lark4_pkg::reg_index_type'(r);
         csr_wdata <= value;
         coef[r] = $signed(value);
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // Result side: random stall bursts, plus a long hold when one is requested.
   initial begin
      int burst;
      burst = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 13) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted result with the oldest outstanding expectation.
   always @(posedge clock) begin : check_results
      next_state_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_states.size() == 0) begin
            report_mismatch("result with no request outstanding", 0, 0);
         end else begin
            want = pending_states.pop_front();
            if (rsp_spring_torque_out !== want.spring)
               report_mismatch("spring torque", rsp_spring_torque_out, $signed(want.spring));
            if (rsp_position_out !== want.position)
               report_mismatch("position", rsp_position_out, $signed(want.position));
            if (rsp_load_speed_out !== want.load_speed)
               report_mismatch("load speed", rsp_load_speed_out, $signed(want.load_speed));
            if (rsp_motor_speed_out !== want.motor_speed)
               report_mismatch("motor speed", rsp_motor_speed_out, $signed(want.motor_speed));
            if (rsp_overflow !== want.overflow)
               report_mismatch("overflow", rsp_overflow, want.overflow);
         end
         results_checked++;
      end
   end

   // Main sequence: reset, directed table, then phases of random requests.
   initial begin
      coef_set_type phase_plan [PHASES];
      int quiet_until;
      phase_plan = '{COEFS_DEFAULT, COEFS_WIDE, COEFS_TOP, COEFS_BOTTOM,
                     COEFS_NONE, COEFS_NEAR, COEFS_WIDE, COEFS_DEFAULT};
      for (int r = 0; r < NUM_REGS; r++) coef[r] = $signed(DEFAULT_COEFS[r]);
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_spring_torque_in <= '0;
      req_position_in      <= '0;
      req_load_speed_in    <= '0;
      req_motor_speed_in   <= '0;
      req_command_in       <= '0;
      csr_write            <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_table[i]) begin
         offer(directed_table[i].stim, directed_table[i].typed, directed_table[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            req_valid <= 1'b0;
            wait_for_results();
            load_coefs(phase_plan[p]);
         end
         idling_on = (p != PHASES - 1);
         quiet_until = 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Long receiver hold while requests keep coming, to fill the pipeline.
            if (p == 1 && n == 30) begin
               hold_left = 90;
               quiet_until = n + 70;
            end
            offer(random_request(), 1'b0, '0);
            if (p == 5 && n == 80) begin
               // Let the pipeline drain completely in the middle of a phase.
               req_valid <= 1'b0;
               wait_for_results();
            end else if (idling_on && n >= quiet_until && $urandom_range(0, 5) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 13)) @(posedge clock);
            end
         end
      end

      req_valid <= 1'b0;
      wait_for_results();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog, well beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### linear_actuator_rk4_step.f
hw/rtl/lark4_pkg.sv
hw/rtl/linear_actuator_rk4_step.sv
sim/tb_top.sv
